// File: sv/pmse_pkg.sv
// Package for the polyline miter stroke expander.
// Holds sizes, register indexes, fixed-point constants and the shared-unit types.
// No dependencies.
`default_nettype none

package pmse_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 18;
  localparam int HW_W       = 12;
  localparam int ALPHA_W    = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOSED = 2'd0;
  localparam logic [1:0] CFG_HW     = 2'd1;
  localparam logic [1:0] CFG_ALPHA  = 2'd2;

  // Fixed-point constants.
  localparam logic [HW_W-1:0] MIN_HW      = 12'd8;
  localparam logic signed [19:0] ONE_Q16   = 20'sd65536;
  localparam logic signed [19:0] LIMIT_Q16 = 20'sd262144;
  localparam logic signed [20:0] QUARTER_Q16 = 21'sd16384;

  // Request to the shared square-root and divide unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] arg;
    logic [31:0] den;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] result;
  } unit_rsp_t;

  // Saturate a wide signed value to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat18(input logic signed [21:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 22'sd131071) begin
      r = 18'sd131071;
    end else if (v < -22'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/pmse_if.sv
// Channel interfaces of the polyline miter stroke expander.
// Point input, ribbon pair output and configuration write channels.
// No dependencies.
`default_nettype none

interface pmse_point_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] point_x;
  logic signed [17:0] point_y;
  logic               last_point;
  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface pmse_pair_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] outer_x;
  logic signed [17:0] outer_y;
  logic signed [17:0] inner_x;
  logic signed [17:0] inner_y;
  logic [11:0]        used_half_width;
  logic [7:0]         faded_alpha;
  logic               last_pair;
  modport source(output valid, outer_x, outer_y, inner_x, inner_y, used_half_width,
                 faded_alpha, last_pair, input ready);
  modport sink(input valid, outer_x, outer_y, inner_x, inner_y, used_half_width,
               faded_alpha, last_pair, output ready);
endinterface

interface pmse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/pmse_unit.sv
// Shared bit-serial unit: floor square root of a 64-bit value, or unsigned
// division of a 48-bit numerator by a 32-bit divisor. Uses pmse_pkg.
`default_nettype none

module pmse_unit
  import pmse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire unit_req_t req,
  output unit_rsp_t      rsp
);

  logic        busy;
  logic        is_sqrt;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [35:0] rem;
  logic [47:0] root;
  logic [31:0] den;
  logic        done;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  // One result bit per cycle: shift in, trial subtract, keep on success.
  always_comb begin
    if (is_sqrt) begin
      rem_sh = {rem[33:0], acc[63:62]};
      trial  = {2'b00, root[31:0], 2'b01};
    end else begin
      rem_sh = {rem[34:0], acc[63]};
      trial  = {4'b0000, den};
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= req.is_sqrt;
        cnt     <= req.is_sqrt ? 6'd31 : 6'd47;
        acc     <= req.arg;
        den     <= req.den;
        rem     <= '0;
        root    <= '0;
      end else if (busy) begin
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[46:0], ge};
        acc  <= is_sqrt ? {acc[61:0], 2'b00} : {acc[62:0], 1'b0};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = root;

endmodule

`default_nettype wire

// File: sv/polyline_miter_stroke_expand.sv
// Polyline miter stroke expander: point store, sequencer and output register.
// Points load at one per cycle while the sequencer is idle; after the last point each
// ribbon pair uses the one-bit-per-cycle root/divide unit: at most for two full
// normals, a join root and three join divisions, less for degenerate segments, a zero
// join sum or the miter limit. A closed ribbon ends with a repeated first pair.
// Reset empties the point count, drops the output valid and restores register defaults.
// Depends on pmse_pkg, pmse_if and pmse_unit.
`default_nettype none

module polyline_miter_stroke_expand
  import pmse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  pmse_point_if.sink    pt,
  pmse_pair_if.source   pr,
  pmse_cfg_if.sink      cfg
);

  typedef enum logic [4:0] {
    S_IDLE, S_PT, S_RDA, S_RDB, S_DIFF, S_SQ1, S_SQ2, S_SQ3, S_SQW,
    S_D1, S_D1W, S_D2, S_D2W, S_VDONE, S_C1, S_C2, S_C3, S_C4, S_KW,
    S_O1, S_O2, S_O3, S_O4, S_O5, S_EMIT, S_REP
  } state_t;

  typedef enum logic [1:0] {PH_NA, PH_NB, PH_MU} phase_t;

  state_t state;
  phase_t phase;

  // Configuration registers.
  logic              closed_mode;
  logic [HW_W-1:0]   half_width;
  logic [ALPHA_W-1:0] stroke_alpha;

  // Point store and per-stroke values.
  logic [35:0]       mem [MAX_POINTS];
  logic [35:0]       rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  point_count;
  logic [IDX_W-1:0]  last_i;
  logic [IDX_W-1:0]  idx_i;
  logic              closed;
  logic [HW_W-1:0]   hwu;
  logic [ALPHA_W-1:0] alpha_u;

  // Datapath registers.
  logic [IDX_W-1:0]  sa, sb;
  logic signed [17:0] xa, ya, cx, cy;
  logic signed [18:0] ux, uy, r1, r2;
  logic signed [18:0] nax, nay, mux, muy;
  logic [31:0]       s;
  logic signed [51:0] acc, prod;
  logic signed [31:0] tx, ty;
  logic signed [20:0] c;
  logic signed [19:0] kq;
  logic signed [20:0] ox, oy;
  logic signed [31:0] ma;
  logic signed [19:0] mb;

  // Output register and saved first pair.
  logic               o_valid;
  logic signed [17:0] o_ox, o_oy, o_ix, o_iy;
  logic [HW_W-1:0]    o_hw;
  logic [ALPHA_W-1:0] o_alpha;
  logic               o_last;
  logic signed [17:0] f_ox, f_oy, f_ix, f_iy;

  unit_req_t ureq;
  unit_rsp_t ursp;

  pmse_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  // Neighbor indexes of the current point and the segment ends for each normal.
  logic [IDX_W-1:0] prev_i, next_i;
  logic [IDX_W-1:0] na_a, na_b, nb_a, nb_b;
  always_comb begin
    prev_i = (idx_i == '0) ? (closed ? last_i : '0) : idx_i - 1'b1;
    next_i = (idx_i == last_i) ? (closed ? '0 : last_i) : idx_i + 1'b1;
    if (idx_i == '0 && !closed) begin
      na_a = idx_i;
      na_b = next_i;
    end else begin
      na_a = prev_i;
      na_b = idx_i;
    end
    if (idx_i == last_i && !closed) begin
      nb_a = prev_i;
      nb_b = idx_i;
    end else begin
      nb_a = idx_i;
      nb_b = next_i;
    end
  end

  // Segment difference from the store.
  logic signed [18:0] dx, dy;
  assign dx = 19'(signed'(rd_q[35:18])) - 19'(xa);
  assign dy = 19'(signed'(rd_q[17:0])) - 19'(ya);

  // Join sum from the two normals.
  logic signed [18:0] mx, my;
  assign mx = nax + r1;
  assign my = nay + r2;

  // Magnitudes of the division numerators.
  logic [18:0] mag1, mag2;
  assign mag1 = ux[18] ? 19'(-ux) : 19'(ux);
  assign mag2 = uy[18] ? 19'(-uy) : 19'(uy);

  // Sum of two squares or dot product, and its rounding by 2^16.
  logic signed [51:0] psum;
  logic [51:0]        pmag;
  logic [35:0]        cq;
  assign psum = acc + prod;
  assign pmag = psum[51] ? 52'(-psum) : 52'(psum);
  assign cq   = 36'((pmag + 52'd32768) >> 16);

  // Rounding of the offset product by 2^32.
  logic [51:0] omag;
  logic [19:0] oq;
  logic signed [20:0] orn;
  assign omag = prod[51] ? 52'(-prod) : 52'(prod);
  assign oq   = 20'((omag + 52'd2147483648) >> 32);
  assign orn  = prod[51] ? -21'(oq) : 21'(oq);

  // Multiplier operands.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_SQ1: begin ma = 32'(ux);  mb = 20'(ux);  end
      S_SQ2: begin ma = 32'(uy);  mb = 20'(uy);  end
      S_C1:  begin ma = 32'(mux); mb = 20'(nax); end
      S_C2:  begin ma = 32'(muy); mb = 20'(nay); end
      S_O1:  begin ma = 32'(mux); mb = 20'(signed'({1'b0, hwu})); end
      S_O2:  begin ma = 32'(muy); mb = 20'(signed'({1'b0, hwu})); end
      S_O3:  begin ma = tx;       mb = kq; end
      S_O4:  begin ma = ty;       mb = kq; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Requests to the shared unit.
  always_comb begin
    ureq = '0;
    unique case (state)
      S_SQ3: begin
        ureq.start   = 1'b1;
        ureq.is_sqrt = 1'b1;
        ureq.arg     = {psum[37:0], 26'd0};
      end
      S_D1: begin
        ureq.start = 1'b1;
        ureq.arg   = {(48'(mag1) << 29) + 48'(s[31:1]), 16'd0};
        ureq.den   = s;
      end
      S_D2: begin
        ureq.start = 1'b1;
        ureq.arg   = {(48'(mag2) << 29) + 48'(s[31:1]), 16'd0};
        ureq.den   = s;
      end
      S_C4: begin
        ureq.start = (c >= QUARTER_Q16);
        ureq.arg   = {48'h0001_0000_0000 + 48'(unsigned'(c) >> 1), 16'd0};
        ureq.den   = 32'(unsigned'(c));
      end
      default: ureq = '0;
    endcase
  end

  // Store read address.
  always_comb begin
    unique case (state)
      S_RDA:   rd_addr = sa;
      S_RDB:   rd_addr = sb;
      default: rd_addr = idx_i;
    endcase
  end

  // Point store.
  logic pt_xfer;
  assign pt_xfer = pt.valid && pt.ready;

  always_ff @(posedge clk) begin
    if (pt_xfer && point_count < CNT_W'(MAX_POINTS)) begin
      mem[point_count[IDX_W-1:0]] <= {pt.point_x, pt.point_y};
    end
    rd_q <= mem[rd_addr];
  end

  // Output pair values.
  logic signed [17:0] e_ox, e_oy, e_ix, e_iy;
  assign e_ox = sat18(22'(cx) + 22'(ox));
  assign e_oy = sat18(22'(cy) + 22'(oy));
  assign e_ix = sat18(22'(cx) - 22'(ox));
  assign e_iy = sat18(22'(cy) - 22'(oy));

  logic out_free;
  assign out_free = !o_valid || pr.ready;

  // A pair is loaded into the output register in this cycle.
  logic emit_fire;
  assign emit_fire = (state == S_EMIT || state == S_REP) && out_free;

  logic [CNT_W-1:0] n_new;
  assign n_new = (point_count < CNT_W'(MAX_POINTS)) ? point_count + 1'b1 : point_count;

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_NA;
      point_count  <= '0;
      o_valid      <= 1'b0;
      closed_mode  <= 1'b0;
      half_width   <= MIN_HW;
      stroke_alpha <= '1;
    end else begin
      if (emit_fire) begin
        o_valid <= 1'b1;
      end else if (pr.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_CLOSED: closed_mode  <= cfg.data[0];
          CFG_HW:     half_width   <= cfg.data;
          CFG_ALPHA:  stroke_alpha <= cfg.data[ALPHA_W-1:0];
          default:    ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (pt_xfer) begin
            if (pt.last_point) begin
              point_count <= '0;
              if (n_new >= CNT_W'(2) && stroke_alpha != '0) begin
                closed <= closed_mode;
                last_i <= IDX_W'(n_new - 1'b1);
                idx_i  <= '0;
                if (half_width < MIN_HW) begin
                  hwu     <= MIN_HW;
                  alpha_u <= ALPHA_W'((11'(stroke_alpha) * 11'(half_width[2:0])) >> 3);
                end else begin
                  hwu     <= half_width;
                  alpha_u <= stroke_alpha;
                end
                state <= S_PT;
              end
            end else begin
              point_count <= n_new;
            end
          end
        end
        S_PT: begin
          sa    <= na_a;
          sb    <= na_b;
          phase <= PH_NA;
          state <= S_RDA;
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          xa    <= signed'(rd_q[35:18]);
          ya    <= signed'(rd_q[17:0]);
          state <= S_DIFF;
        end
        S_DIFF: begin
          if (dx == '0 && dy == '0) begin
            r1    <= '0;
            r2    <= '0;
            state <= S_VDONE;
          end else begin
            ux    <= -dy;
            uy    <= dx;
            state <= S_SQ1;
          end
        end
        S_SQ1: state <= S_SQ2;
        S_SQ2: begin
          acc   <= prod;
          state <= S_SQ3;
        end
        S_SQ3: state <= S_SQW;
        S_SQW: begin
          if (ursp.done) begin
            s     <= ursp.result[31:0];
            state <= S_D1;
          end
        end
        S_D1: state <= S_D1W;
        S_D1W: begin
          if (ursp.done) begin
            r1    <= ux[18] ? -19'(ursp.result) : 19'(ursp.result);
            state <= S_D2;
          end
        end
        S_D2: state <= S_D2W;
        S_D2W: begin
          if (ursp.done) begin
            r2    <= uy[18] ? -19'(ursp.result) : 19'(ursp.result);
            state <= S_VDONE;
          end
        end
        S_VDONE: begin
          unique case (phase)
            PH_NA: begin
              nax   <= r1;
              nay   <= r2;
              sa    <= nb_a;
              sb    <= nb_b;
              phase <= PH_NB;
              state <= S_RDA;
            end
            PH_NB: begin
              if (mx == '0 && my == '0) begin
                // Opposite normals: keep the first one, no miter scaling.
                mux   <= nax;
                muy   <= nay;
                kq    <= ONE_Q16;
                state <= S_O1;
              end else begin
                ux    <= mx;
                uy    <= my;
                phase <= PH_MU;
                state <= S_SQ1;
              end
            end
            default: begin
              mux   <= r1;
              muy   <= r2;
              state <= S_C1;
            end
          endcase
        end
        S_C1: state <= S_C2;
        S_C2: begin
          acc   <= prod;
          state <= S_C3;
        end
        S_C3: begin
          c     <= psum[51] ? -21'(cq) : 21'(cq);
          state <= S_C4;
        end
        S_C4: begin
          if (c < QUARTER_Q16) begin
            kq    <= LIMIT_Q16;
            state <= S_O1;
          end else begin
            state <= S_KW;
          end
        end
        S_KW: begin
          if (ursp.done) begin
            kq    <= 20'(ursp.result);
            state <= S_O1;
          end
        end
        S_O1: state <= S_O2;
        S_O2: begin
          tx    <= prod[31:0];
          cx    <= signed'(rd_q[35:18]);
          cy    <= signed'(rd_q[17:0]);
          state <= S_O3;
        end
        S_O3: begin
          ty    <= prod[31:0];
          state <= S_O4;
        end
        S_O4: begin
          ox    <= orn;
          state <= S_O5;
        end
        S_O5: begin
          oy    <= orn;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            o_ox    <= e_ox;
            o_oy    <= e_oy;
            o_ix    <= e_ix;
            o_iy    <= e_iy;
            o_hw    <= hwu;
            o_alpha <= alpha_u;
            o_last  <= !closed && idx_i == last_i;
            if (idx_i == '0) begin
              f_ox <= e_ox;
              f_oy <= e_oy;
              f_ix <= e_ix;
              f_iy <= e_iy;
            end
            if (idx_i == last_i) begin
              state <= closed ? S_REP : S_IDLE;
            end else begin
              idx_i <= idx_i + 1'b1;
              state <= S_PT;
            end
          end
        end
        S_REP: begin
          // Closed ribbon ends by repeating the first pair.
          if (out_free) begin
            o_ox    <= f_ox;
            o_oy    <= f_oy;
            o_ix    <= f_ix;
            o_iy    <= f_iy;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pt.ready   = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign pr.valid   = o_valid;
  assign pr.outer_x = o_ox;
  assign pr.outer_y = o_oy;
  assign pr.inner_x = o_ix;
  assign pr.inner_y = o_iy;
  assign pr.used_half_width = o_hw;
  assign pr.faded_alpha     = o_alpha;
  assign pr.last_pair       = o_last;

  // The store never counts past its size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds store size");

  // A final point always empties the store count.
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (pt_xfer && pt.last_point) |=> point_count == '0)
    else $error("store count not cleared after final point");

  // The shared unit only finishes while the sequencer waits for it.
  a_unit_wait: assert property (@(posedge clk) disable iff (rst)
    ursp.done |-> (state == S_SQW || state == S_D1W || state == S_D2W || state == S_KW))
    else $error("unit result arrived outside a wait state");

  // A waiting pair holds its value until it is taken.
  a_pair_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !pr.ready) |=> (o_valid && $stable({o_ox, o_oy, o_ix, o_iy, o_last})))
    else $error("pending pair changed before its transfer");

endmodule

`default_nettype wire

// File: tb/tb_pmse_if_note.sv
// Shared testbench types for the polyline miter stroke expander bench.
// Holds the expected ribbon pair record and the point item; depends on nothing.
`timescale 1ns / 1ps

package tb_pmse_types;

  // One ribbon vertex pair as the block should present it.
  typedef struct {
    logic signed [17:0] outer_x;
    logic signed [17:0] outer_y;
    logic signed [17:0] inner_x;
    logic signed [17:0] inner_y;
    logic [11:0]        used_half_width;
    logic [7:0]         faded_alpha;
    logic               last_pair;
  } ribbon_pair_t;

  // One point waiting to be sent.
  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic               last;
  } point_item_t;

endpackage

// File: tb/tb_top.sv
// Self-checking bench for polyline_miter_stroke_expand: polylines are sent
// through the point channel and every ribbon pair is checked against a
// fixed-point predictor. Depends on pmse_pkg, pmse_if and tb_pmse_types.
`timescale 1ns / 1ps

module tb_top;
  import pmse_pkg::*;
  import tb_pmse_types::*;

  localparam int STORE_DEPTH = 32;
  localparam int DRAIN_CYCLES = 2000;

  logic clk;
  logic rst;

  pmse_point_if pt();
  pmse_pair_if  pr();
  pmse_cfg_if   cfg();

  polyline_miter_stroke_expand DUT (
    .clk(clk), .rst(rst), .pt(pt.sink), .pr(pr.source), .cfg(cfg.sink)
  );

  // Predictor state and register shadows.
  logic               shadow_closed;
  logic [11:0]        shadow_hw;
  logic [7:0]         shadow_alpha;
  logic signed [17:0] poly_x [STORE_DEPTH];
  logic signed [17:0] poly_y [STORE_DEPTH];
  int                 poly_count;

  point_item_t  pending_points[$];
  ribbon_pair_t expected_pairs[$];
  int           error_count;
  int           pairs_checked;
  int           polylines_sent;
  int           send_idle_pct;
  int           recv_stall_pct;

  // Clock; the single reset is driven by the stimulus block.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor integer square root.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_round(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [17:0] clamp_coord(input longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[17:0];
  endfunction

  // Unit normal (Q1.16) of the segment from point a to point b.
  task automatic segment_normal(input int a, input int b, output longint nx,
                                output longint ny);
    longint dx;
    longint dy;
    longint unsigned s;
    dx = longint'(poly_x[b]) - longint'(poly_x[a]);
    dy = longint'(poly_y[b]) - longint'(poly_y[a]);
    if (dx == 0 && dy == 0) begin
      nx = 0;
      ny = 0;
    end else begin
      s = root_floor(longint'(dx * dx + dy * dy) << 26);
      nx = div_round(-dy * (64'sd1 <<< 29), s);
      ny = div_round(dx * (64'sd1 <<< 29), s);
    end
  endtask

  // Expand the stored polyline into expected ribbon pairs.
  task automatic expand_ribbon();
    int n;
    int prv;
    int nxt;
    longint hw;
    longint alpha;
    longint nax, nay, nbx, nby, mx, my, mux, muy, kq, ox, oy, c;
    longint unsigned s;
    ribbon_pair_t p;
    ribbon_pair_t first;
    n = poly_count;
    poly_count = 0;
    if (n < 2 || shadow_alpha == 0) return;
    hw = shadow_hw;
    alpha = shadow_alpha;
    if (hw < 8) begin
      alpha = alpha * hw / 8;
      hw = 8;
    end
    for (int i = 0; i < n; i++) begin
      prv = (i == 0) ? (shadow_closed ? n - 1 : 0) : i - 1;
      nxt = (i == n - 1) ? (shadow_closed ? 0 : n - 1) : i + 1;
      if (i == 0 && !shadow_closed) segment_normal(i, nxt, nax, nay);
      else segment_normal(prv, i, nax, nay);
      if (i == n - 1 && !shadow_closed) segment_normal(prv, i, nbx, nby);
      else segment_normal(i, nxt, nbx, nby);
      mx = nax + nbx;
      my = nay + nby;
      if (mx == 0 && my == 0) begin
        mux = nax;
        muy = nay;
        kq = 65536;
      end else begin
        s = root_floor(longint'(mx * mx + my * my) << 26);
        mux = div_round(mx * (64'sd1 <<< 29), s);
        muy = div_round(my * (64'sd1 <<< 29), s);
        c = div_round(mux * nax + muy * nay, 65536);
        if (c < 16384) kq = 262144;
        else kq = div_round(64'sd1 <<< 32, c);
      end
      ox = div_round(mux * hw * kq, 64'd1 << 32);
      oy = div_round(muy * hw * kq, 64'd1 << 32);
      p.outer_x = clamp_coord(poly_x[i] + ox);
      p.outer_y = clamp_coord(poly_y[i] + oy);
      p.inner_x = clamp_coord(poly_x[i] - ox);
      p.inner_y = clamp_coord(poly_y[i] - oy);
      p.used_half_width = hw[11:0];
      p.faded_alpha = alpha[7:0];
      p.last_pair = (!shadow_closed && i == n - 1);
      if (i == 0) first = p;
      expected_pairs.push_back(p);
    end
    if (shadow_closed) begin
      first.last_pair = 1'b1;
      expected_pairs.push_back(first);
    end
  endtask

  // Driver: offers the next pending point, with random idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
    end else begin
      if (pt.valid && pt.ready) void'(pending_points.pop_front());
      if ((pt.valid && !pt.ready) ||
          (pending_points.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)) begin
        pt.valid <= 1'b1;
        pt.point_x <= pending_points[0].x;
        pt.point_y <= pending_points[0].y;
        pt.last_point <= pending_points[0].last;
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Predictor update on every accepted point transfer.
  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready) begin
      if (poly_count < STORE_DEPTH) begin
        poly_x[poly_count] = pt.point_x;
        poly_y[poly_count] = pt.point_y;
        poly_count = poly_count + 1;
      end
      if (pt.last_point) expand_ribbon();
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk) begin
    ribbon_pair_t e;
    if (rst) begin
      pr.ready <= 1'b0;
    end else begin
      if (pr.valid && pr.ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected pair transfer outer=(%0d,%0d)", $time,
                   pr.outer_x, pr.outer_y);
          error_count++;
        end else begin
          e = expected_pairs.pop_front();
          pairs_checked++;
          if (e.outer_x !== pr.outer_x || e.outer_y !== pr.outer_y ||
              e.inner_x !== pr.inner_x || e.inner_y !== pr.inner_y ||
              e.used_half_width !== pr.used_half_width ||
              e.faded_alpha !== pr.faded_alpha || e.last_pair !== pr.last_pair) begin
            $display("%0t: mismatch expected o=(%0d,%0d) i=(%0d,%0d) hw=%0d a=%0d l=%0b",
                     $time, e.outer_x, e.outer_y, e.inner_x, e.inner_y,
                     e.used_half_width, e.faded_alpha, e.last_pair);
            $display("%0t:          actual   o=(%0d,%0d) i=(%0d,%0d) hw=%0d a=%0d l=%0b",
                     $time, pr.outer_x, pr.outer_y, pr.inner_x, pr.inner_y,
                     pr.used_half_width, pr.faded_alpha, pr.last_pair);
            error_count++;
          end
        end
      end
      pr.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Write one register while the block is idle.
  task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
    cfg.index <= idx;
    cfg.data <= value;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_CLOSED: shadow_closed = value[0];
      CFG_HW:     shadow_hw = value;
      default:    shadow_alpha = value[7:0];
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || pt.valid || expected_pairs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [17:0] any_coord();
    case ($urandom_range(9, 0))
      0: return 18'sh1FFFF;
      1: return -18'sh20000;
      default: return 18'($urandom_range(2000, 0) - 1000);
    endcase
  endfunction

  // Queue a polyline of the given length; points are spread or clustered.
  task automatic queue_polyline(input int len, input bit wide);
    point_item_t p;
    logic signed [17:0] bx;
    logic signed [17:0] by;
    bx = 18'($urandom_range(4000, 0) - 2000);
    by = 18'($urandom_range(4000, 0) - 2000);
    for (int i = 0; i < len; i++) begin
      if (wide) begin
        p.x = 18'($urandom());
        p.y = 18'($urandom());
        if ($urandom_range(7, 0) == 0) p.x = any_coord();
      end else begin
        p.x = 18'(bx + $urandom_range(800, 0) - 400);
        p.y = 18'(by + $urandom_range(800, 0) - 400);
        if ($urandom_range(9, 0) == 0 && i > 0) begin
          p.x = pending_points[$].x;
          p.y = pending_points[$].y;
        end
      end
      p.last = (i == len - 1);
      pending_points.push_back(p);
    end
    polylines_sent++;
  endtask

  function automatic point_item_t mk(input int x, input int y, input bit last);
    point_item_t p;
    p.x = 18'(x);
    p.y = 18'(y);
    p.last = last;
    return p;
  endfunction

  // Stimulus and phases.
  initial begin
    int phase;
    rst = 1'b1;
    poly_count = 0;
    error_count = 0;
    pairs_checked = 0;
    polylines_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_closed = 1'b0;
    shadow_hw = 12'd8;
    shadow_alpha = 8'd255;
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.last_point = 1'b0;
    pr.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_CLOSED;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, a hairpin, degenerate segments, single point, a right-angle turn.
    pending_points.push_back(mk(131071, -131072, 0));
    pending_points.push_back(mk(-131072, 131071, 1));
    pending_points.push_back(mk(0, 0, 0));
    pending_points.push_back(mk(160, 0, 0));
    pending_points.push_back(mk(0, 0, 1));
    pending_points.push_back(mk(5, 5, 0));
    pending_points.push_back(mk(5, 5, 0));
    pending_points.push_back(mk(5, 5, 1));
    pending_points.push_back(mk(7, 7, 1));
    pending_points.push_back(mk(0, 0, 0));
    pending_points.push_back(mk(100, 0, 0));
    pending_points.push_back(mk(100, 100, 1));
    wait_drained();

    // Closed, thin and invisible strokes, then widest.
    write_register(CFG_CLOSED, 12'd1);
    write_register(CFG_HW, 12'd0);
    queue_polyline(4, 0);
    wait_drained();
    write_register(CFG_HW, 12'd3);
    queue_polyline(3, 0);
    wait_drained();
    write_register(CFG_ALPHA, 12'd0);
    queue_polyline(3, 0);
    wait_drained();
    write_register(CFG_ALPHA, 12'd255);
    write_register(CFG_HW, 12'd4095);
    write_register(CFG_CLOSED, 12'd0);
    queue_polyline(3, 1);
    wait_drained();
    // Overflow of the store: a polyline longer than it holds.
    write_register(CFG_HW, 12'd20);
    queue_polyline(36, 0);
    wait_drained();

    // Random phases with changing idle patterns and settings.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      write_register(CFG_CLOSED, 12'($urandom_range(1, 0)));
      write_register(CFG_HW, 12'(($urandom_range(3, 0) == 0) ? $urandom_range(9, 0)
                                                             : $urandom_range(4095, 0)));
      write_register(CFG_ALPHA, 12'(($urandom_range(7, 0) == 0) ? 0
                                                                : $urandom_range(255, 1)));
      for (int k = 0; k < 12; k++) begin
        queue_polyline(($urandom_range(9, 0) == 0) ? $urandom_range(34, 2)
                                                   : $urandom_range(5, 1),
                       $urandom_range(3, 0) == 0);
        // Hold off now and then until the ribbon has fully drained.
        if (k == 5) wait_drained();
      end
      wait_drained();
    end

    $display("Covered %0d polylines, %0d ribbon pairs checked, open and closed modes,",
             polylines_sent, pairs_checked);
    $display("thin, invisible and wide strokes, store overflow and random stalls.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #400000000;
    $display("Timeout with %0d pairs still expected", expected_pairs.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
